>>> rtl/tbc_pkg.sv
// Shared types, constants and helpers for the gap-buffer text block.
package tbc_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CHAR_W      = 8;
    localparam int OPCODE_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MOVE_LEFT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MOVE_RIGHT = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SHOW_RIGHT = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_FULL_TEXT  = 3'd5;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_INSERT,
        CMD_DELETE,
        CMD_MOVE_LEFT,
        CMD_MOVE_RIGHT,
        CMD_SHOW_RIGHT,
        CMD_SHOW_ALL
    } cmd_kind_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   char_in;
        logic [COUNT_W-1:0]  count;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic               char_valid;
        logic [COUNT_W-1:0] cursor_pos;
        logic [COUNT_W-1:0] text_length;
        logic [COUNT_W-1:0] done_count;
        logic               full_error;
        logic               last;
    } out_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    // Smaller of the requested count and the characters available on one side.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] k,
                                                     input logic [CNT_W-1:0] avail);
        logic [COUNT_W-1:0] avail_ext;
        avail_ext = COUNT_W'(avail);
        if (k < avail_ext)
            return CNT_W'(k);
        return avail;
    endfunction

endpackage

>>> rtl/text_buffer_with_cursor.sv
// Text buffer with cursor, kept as a gap buffer in one character RAM.
//
// Requests arrive on in_valid/in_ready/in_data, one operation per request:
// insert a character, delete left, move the cursor, show right or show all.
// Results leave on out_valid/out_ready/out_data; every result carries the
// cursor position, the text length and the number of characters handled.
// A request passes a decode stage and a two-entry command queue before the
// executor. A move carries one character per cycle through the single RAM
// read port, with each write in the cycle after its read.
// A show streams one character per cycle while out_ready stays high, up to
// 64 results per request.
// When the receiver stalls, the result register holds, the executor waits
// with at most one character parked in the RAM read register, and the
// queue and decode stage keep taking requests until they fill.
// Reset empties the text and puts the cursor at zero; the RAM contents are
// not cleared and no entry is read before it has been written.
module text_buffer_with_cursor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tbc_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tbc_pkg::out_t  out_data
);

    logic          front_valid;
    logic          front_ready;
    tbc_pkg::cmd_t front_cmd;
    logic          exec_valid;
    logic          exec_ready;
    tbc_pkg::cmd_t exec_cmd;

    tbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    tbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (exec_valid),
        .pop_ready  (exec_ready),
        .pop_cmd    (exec_cmd)
    );

    tbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (exec_valid),
        .cmd_ready (exec_ready),
        .cmd       (exec_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/tbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read data holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> rtl/tbc_front.sv
// Front end: accepts requests, decodes the opcode and stages one command.
module tbc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tbc_pkg::in_t   in_data,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output tbc_pkg::cmd_t  cmd
);

    logic          stage_valid_reg;
    tbc_pkg::cmd_t stage_reg;
    tbc_pkg::cmd_t stage_next;

    assign in_ready  = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_reg;

    always_comb
    begin
        stage_next.ch    = in_data.char_in;
        stage_next.count = in_data.count;
        unique case (in_data.opcode)
            tbc_pkg::OP_INSERT:     stage_next.kind = tbc_pkg::CMD_INSERT;
            tbc_pkg::OP_DELETE:     stage_next.kind = tbc_pkg::CMD_DELETE;
            tbc_pkg::OP_MOVE_LEFT:  stage_next.kind = tbc_pkg::CMD_MOVE_LEFT;
            tbc_pkg::OP_MOVE_RIGHT: stage_next.kind = tbc_pkg::CMD_MOVE_RIGHT;
            tbc_pkg::OP_SHOW_RIGHT: stage_next.kind = tbc_pkg::CMD_SHOW_RIGHT;
            tbc_pkg::OP_FULL_TEXT:  stage_next.kind = tbc_pkg::CMD_SHOW_ALL;
            default:                stage_next.kind = tbc_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_reg <= stage_next;
    end

endmodule

>>> rtl/tbc_queue.sv
// Short command queue between the front end and the execution back end.
module tbc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tbc_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tbc_pkg::cmd_t  pop_cmd
);

    localparam int PTR_W  = $clog2(tbc_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(tbc_pkg::QUEUE_DEPTH + 1);

    tbc_pkg::cmd_t     entries_reg [tbc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign push_ready = (fill_reg != FILL_W'(tbc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                fill_reg <= fill_reg + FILL_W'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> rtl/tbc_back.sv
// Back end: owns the gap buffer, carries out commands and drives results.
module tbc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  tbc_pkg::cmd_t  cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output tbc_pkg::out_t  out_data
);

    localparam int ADDR_W = tbc_pkg::ADDR_W;
    localparam int CNT_W  = tbc_pkg::CNT_W;
    localparam int CW     = tbc_pkg::COUNT_W;

    typedef enum logic [1:0] {S_IDLE, S_MOVE, S_SHOW, S_STAT} state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             left_reg, left_next;
    logic [CNT_W-1:0]             right_reg, right_next;
    logic [CNT_W-1:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]             done_reg, done_next;
    logic                         err_reg, err_next;
    logic                         dir_right_reg, dir_right_next;
    logic [ADDR_W-1:0]            rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0]            wr_addr_reg, wr_addr_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic                         pend_reg, pend_next;
    logic                         pend_last_reg, pend_last_next;
    logic                         out_valid_reg, out_valid_next;
    tbc_pkg::out_t                out_reg, out_next;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [tbc_pkg::CHAR_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [tbc_pkg::CHAR_W-1:0]   ram_rdata;

    logic [CNT_W-1:0]             total;
    logic [CNT_W-1:0]             gap;
    logic                         full;
    logic [CNT_W-1:0]             d_left;
    logic [CNT_W-1:0]             d_right;
    logic [ADDR_W-1:0]            show_addr;
    logic                         out_free;
    logic                         load;
    logic                         issue;

    assign total     = left_reg + right_reg;
    assign gap       = CNT_W'(tbc_pkg::CAPACITY) - total;
    assign full      = (total == CNT_W'(tbc_pkg::CAPACITY));
    assign d_left    = tbc_pkg::clamp_count(cmd.count, left_reg);
    assign d_right   = tbc_pkg::clamp_count(cmd.count, right_reg);
    // Text position to store address: the right part sits past the gap.
    assign show_addr = (idx_reg < left_reg) ? ADDR_W'(idx_reg) : ADDR_W'(idx_reg + gap);
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    tbc_ram #(
        .WIDTH (tbc_pkg::CHAR_W),
        .DEPTH (tbc_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        rem_next       = rem_reg;
        done_next      = done_reg;
        err_next       = err_reg;
        dir_right_next = dir_right_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        load           = 1'b0;
        issue          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    err_next   = 1'b0;
                    done_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_STAT;
                    unique case (cmd.kind)
                        tbc_pkg::CMD_INSERT:
                        begin
                            if (full)
                                err_next = 1'b1;
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(left_reg);
                                ram_wdata = cmd.ch;
                                left_next = left_reg + CNT_W'(1);
                                done_next = CNT_W'(1);
                            end
                        end
                        tbc_pkg::CMD_DELETE:
                        begin
                            left_next = left_reg - d_left;
                            done_next = d_left;
                        end
                        tbc_pkg::CMD_MOVE_LEFT:
                        begin
                            done_next      = d_left;
                            rem_next       = d_left;
                            dir_right_next = 1'b0;
                            rd_addr_next   = ADDR_W'(left_reg - CNT_W'(1));
                            wr_addr_next   = ADDR_W'(CNT_W'(tbc_pkg::CAPACITY - 1) - right_reg);
                            if (d_left != '0)
                                state_next = S_MOVE;
                        end
                        tbc_pkg::CMD_MOVE_RIGHT:
                        begin
                            done_next      = d_right;
                            rem_next       = d_right;
                            dir_right_next = 1'b1;
                            rd_addr_next   = ADDR_W'(CNT_W'(tbc_pkg::CAPACITY) - right_reg);
                            wr_addr_next   = ADDR_W'(left_reg);
                            if (d_right != '0)
                                state_next = S_MOVE;
                        end
                        tbc_pkg::CMD_SHOW_RIGHT:
                        begin
                            done_next = d_right;
                            rem_next  = d_right;
                            idx_next  = left_reg;
                            if (d_right != '0)
                                state_next = S_SHOW;
                        end
                        tbc_pkg::CMD_SHOW_ALL:
                        begin
                            done_next = total;
                            rem_next  = total;
                            idx_next  = '0;
                            if (total != '0)
                                state_next = S_SHOW;
                        end
                        default:
                        begin
                            done_next = '0;
                        end
                    endcase
                end
            end

            // One character moves across the gap per cycle: the read is issued
            // in the cycle before the matching write.
            S_MOVE:
            begin
                if (rem_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_addr_reg;
                    rem_next     = rem_reg - CNT_W'(1);
                    rd_addr_next = dir_right_reg ? rd_addr_reg + ADDR_W'(1)
                                                 : rd_addr_reg - ADDR_W'(1);
                end
                pend_next = (rem_reg != '0);
                if (pend_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = wr_addr_reg;
                    ram_wdata    = ram_rdata;
                    wr_addr_next = dir_right_reg ? wr_addr_reg + ADDR_W'(1)
                                                 : wr_addr_reg - ADDR_W'(1);
                    if (dir_right_reg)
                    begin
                        left_next  = left_reg + CNT_W'(1);
                        right_next = right_reg - CNT_W'(1);
                    end
                    else
                    begin
                        left_next  = left_reg - CNT_W'(1);
                        right_next = right_reg + CNT_W'(1);
                    end
                end
                if (rem_reg == '0)
                    state_next = S_STAT;
            end

            // The read data register holds a fetched character until the
            // output register can take it.
            S_SHOW:
            begin
                load  = pend_reg && out_free;
                issue = (rem_reg != '0) && (!pend_reg || load);
                if (load)
                begin
                    out_valid_next       = 1'b1;
                    out_next.char_out    = ram_rdata;
                    out_next.char_valid  = 1'b1;
                    out_next.cursor_pos  = CW'(left_reg);
                    out_next.text_length = CW'(total);
                    out_next.done_count  = CW'(done_reg);
                    out_next.full_error  = 1'b0;
                    out_next.last        = pend_last_reg;
                end
                if (issue)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = show_addr;
                    idx_next       = idx_reg + CNT_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                    pend_last_next = (rem_reg == CNT_W'(1));
                end
                pend_next = issue || (pend_reg && !load);
                if ((rem_reg == '0) && !pend_next)
                    state_next = S_IDLE;
            end

            S_STAT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.char_out    = '0;
                    out_next.char_valid  = 1'b0;
                    out_next.cursor_pos  = CW'(left_reg);
                    out_next.text_length = CW'(total);
                    out_next.done_count  = CW'(done_reg);
                    out_next.full_error  = err_reg;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            rem_reg       <= '0;
            done_reg      <= '0;
            err_reg       <= 1'b0;
            dir_right_reg <= 1'b0;
            rd_addr_reg   <= '0;
            wr_addr_reg   <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            rem_reg       <= rem_next;
            done_reg      <= done_next;
            err_reg       <= err_next;
            dir_right_reg <= dir_right_next;
            rd_addr_reg   <= rd_addr_next;
            wr_addr_reg   <= wr_addr_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

>>> rtl/tbc_checker.sv
// Port-level checks on the text buffer results, bound to the top level.
module tbc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input tbc_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.char_valid |-> out_data.last)
        else $error("status result without last");

    a_full_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.full_error |->
            out_data.done_count == '0 && !out_data.char_valid &&
            out_data.text_length == 7'(tbc_pkg::CAPACITY))
        else $error("refused insert with inconsistent status");

    a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.char_valid |-> out_data.done_count != '0)
        else $error("character result with zero count");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.text_length >= out_data.cursor_pos &&
            out_data.text_length <= 7'(tbc_pkg::CAPACITY))
        else $error("cursor or length out of range");

endmodule

bind text_buffer_with_cursor tbc_checker u_checker (.*);

>>> test/tb_text_buffer_with_cursor.sv
// Self-checking testbench for the gap-buffer text block with cursor.
module tb_text_buffer_with_cursor;

    localparam int OPCODE_W = tbc_pkg::OPCODE_W;
    localparam int CHAR_W   = tbc_pkg::CHAR_W;
    localparam int COUNT_W  = tbc_pkg::COUNT_W;
    localparam int CAPACITY = tbc_pkg::CAPACITY;

    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;
    localparam int MAX_IDLE        = 8;
    localparam int LONG_STALL      = 300;
    localparam int SETTLE_CYCLES   = 80;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int RANDOM_REQUESTS = 330;
    localparam int SEGMENT_LEN     = 30;
    localparam int REPORT_LIMIT    = 200;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    tbc_pkg::in_t  in_data  = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    tbc_pkg::out_t out_data;

    // Shadow copy of the editor state, advanced as each request is accepted.
    logic [CHAR_W-1:0] text_mem [CAPACITY];
    int   left_len  = 0;
    int   right_len = 0;
    tbc_pkg::out_t expected_results [$];

    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int refused_inserts = 0;
    int longest_reply   = 0;
    bit sender_idle     = 1'b1;
    bit sink_idle       = 1'b1;
    bit long_stall_req  = 1'b0;
    int unsigned cycle_count = 0;

    text_buffer_with_cursor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("text_buffer_with_cursor regression: fail");
        $finish;
    end

    function automatic tbc_pkg::out_t make_result(input logic [CHAR_W-1:0] ch,
                                                  input logic valid,
                                                  input int done, input logic err,
                                                  input logic is_last);
        tbc_pkg::out_t r;
        r.char_out    = ch;
        r.char_valid  = valid;
        r.cursor_pos  = COUNT_W'(left_len);
        r.text_length = COUNT_W'(left_len + right_len);
        r.done_count  = COUNT_W'(done);
        r.full_error  = err;
        r.last        = is_last;
        return r;
    endfunction

    // Applies one edit to the shadow state and queues the results it must produce.
    function automatic void predict_edit(input tbc_pkg::in_t req);
        int k;
        int d;
        int n;
        int idx;
        k = int'(req.count);
        case (req.opcode)
            tbc_pkg::OP_INSERT:
            begin
                if (left_len + right_len >= CAPACITY)
                begin
                    expected_results.push_back(make_result('0, 1'b0, 0, 1'b1, 1'b1));
                    refused_inserts++;
                end
                else
                begin
                    text_mem[left_len] = req.char_in;
                    left_len++;
                    expected_results.push_back(make_result('0, 1'b0, 1, 1'b0, 1'b1));
                end
            end
            tbc_pkg::OP_DELETE:
            begin
                d = (k < left_len) ? k : left_len;
                left_len -= d;
                expected_results.push_back(make_result('0, 1'b0, d, 1'b0, 1'b1));
            end
            tbc_pkg::OP_MOVE_LEFT:
            begin
                d = (k < left_len) ? k : left_len;
                for (int i = 0; i < d; i++)
                begin
                    text_mem[CAPACITY - right_len - 1] = text_mem[left_len - 1];
                    left_len--;
                    right_len++;
                end
                expected_results.push_back(make_result('0, 1'b0, d, 1'b0, 1'b1));
            end
            tbc_pkg::OP_MOVE_RIGHT:
            begin
                d = (k < right_len) ? k : right_len;
                for (int i = 0; i < d; i++)
                begin
                    text_mem[left_len] = text_mem[CAPACITY - right_len];
                    left_len++;
                    right_len--;
                end
                expected_results.push_back(make_result('0, 1'b0, d, 1'b0, 1'b1));
            end
            tbc_pkg::OP_SHOW_RIGHT:
            begin
                d = (k < right_len) ? k : right_len;
                if (d == 0)
                    expected_results.push_back(make_result('0, 1'b0, 0, 1'b0, 1'b1));
                for (int i = 0; i < d; i++)
                    expected_results.push_back(make_result(text_mem[CAPACITY - right_len + i],
                                                           1'b1, d, 1'b0, i == d - 1));
                if (d > longest_reply)
                    longest_reply = d;
            end
            tbc_pkg::OP_FULL_TEXT:
            begin
                n = left_len + right_len;
                if (n == 0)
                    expected_results.push_back(make_result('0, 1'b0, 0, 1'b0, 1'b1));
                for (int i = 0; i < n; i++)
                begin
                    idx = (i < left_len) ? i : CAPACITY - right_len + (i - left_len);
                    expected_results.push_back(make_result(text_mem[idx], 1'b1, n, 1'b0,
                                                           i == n - 1));
                end
                if (n > longest_reply)
                    longest_reply = n;
            end
            default:
                expected_results.push_back(make_result('0, 1'b0, 0, 1'b0, 1'b1));
        endcase
    endfunction

    function automatic tbc_pkg::in_t edit_req(input logic [OPCODE_W-1:0] op,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [COUNT_W-1:0] cnt);
        tbc_pkg::in_t req;
        req.opcode  = op;
        req.char_in = ch;
        req.count   = cnt;
        return req;
    endfunction

    // Random edit; grow_pct sets how often it is an insert.
    function automatic tbc_pkg::in_t random_edit(input int grow_pct);
        tbc_pkg::in_t req;
        int           pick;
        req.char_in = CHAR_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            req.count = COUNT_W'($urandom_range(0, 8));
        else if (pick < 95)
            req.count = COUNT_W'($urandom_range(0, CAPACITY));
        else
            req.count = COUNT_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < grow_pct)
            req.opcode = tbc_pkg::OP_INSERT;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                req.opcode = tbc_pkg::OP_DELETE;
            else if (pick < 40)
                req.opcode = tbc_pkg::OP_MOVE_LEFT;
            else if (pick < 60)
                req.opcode = tbc_pkg::OP_MOVE_RIGHT;
            else if (pick < 78)
                req.opcode = tbc_pkg::OP_SHOW_RIGHT;
            else if (pick < 94)
                req.opcode = tbc_pkg::OP_FULL_TEXT;
            else if (pick < 97)
                req.opcode = OP_SPARE_A;
            else
                req.opcode = OP_SPARE_B;
        end
        return req;
    endfunction

    // Valid stays high after acceptance so that a back-to-back request needs
    // only one assignment; whoever waits next lowers it first.
    task automatic send_request(input tbc_pkg::in_t req);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_edit(req);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [CHAR_W-1:0] want,
                                 input logic [CHAR_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result(input tbc_pkg::out_t got);
        tbc_pkg::out_t want;
        results_checked++;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $error("result with no request outstanding: %p", got);
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("char_out", want.char_out, got.char_out);
            compare_field("char_valid", CHAR_W'(want.char_valid), CHAR_W'(got.char_valid));
            compare_field("cursor_pos", CHAR_W'(want.cursor_pos), CHAR_W'(got.cursor_pos));
            compare_field("text_length", CHAR_W'(want.text_length),
                          CHAR_W'(got.text_length));
            compare_field("done_count", CHAR_W'(want.done_count), CHAR_W'(got.done_count));
            compare_field("full_error", CHAR_W'(want.full_error), CHAR_W'(got.full_error));
            compare_field("last", CHAR_W'(want.last), CHAR_W'(got.last));
        end
    endtask

    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                hold = LONG_STALL;
                long_stall_req = 1'b0;
            end
            else
                hold = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_result(out_data);
        end
    end

    task automatic test_directed_edits();
        sender_idle = 1'b1;
        sink_idle   = 1'b1;
        // Empty buffer: shows give one status result, every count clamps to zero.
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd5));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'h00, 7'd0));
        send_request(edit_req(tbc_pkg::OP_DELETE, 8'h00, 7'd3));
        send_request(edit_req(tbc_pkg::OP_MOVE_LEFT, 8'h00, 7'd1));
        send_request(edit_req(tbc_pkg::OP_MOVE_RIGHT, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h00, 7'd0));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'hff, 7'd127));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h41, 7'd64));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h80, 7'd1));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'hff, 7'd127));
        send_request(edit_req(tbc_pkg::OP_MOVE_LEFT, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd0));
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd64));
        send_request(edit_req(tbc_pkg::OP_MOVE_RIGHT, 8'h00, 7'd2));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h7f, 7'd0));
        send_request(edit_req(tbc_pkg::OP_DELETE, 8'h00, 7'd0));
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd1));
        send_request(edit_req(OP_SPARE_A, 8'hff, 7'd127));
        send_request(edit_req(OP_SPARE_B, 8'h55, 7'd64));
        send_request(edit_req(tbc_pkg::OP_DELETE, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'h00, 7'd3));
        send_request(edit_req(tbc_pkg::OP_MOVE_LEFT, 8'h00, 7'd1));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'h00, 7'd0));
        wait_for_results();
    endtask

    task automatic test_full_buffer();
        int room;
        room = CAPACITY - (left_len + right_len);
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        repeat (room)
            send_request(edit_req(tbc_pkg::OP_INSERT, CHAR_W'($urandom_range(0, 255)),
                                  COUNT_W'($urandom_range(0, 127))));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'hff, 7'd0));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_MOVE_LEFT, 8'h00, 7'd64));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h33, 7'd0));
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd64));
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd127));
        sink_idle = 1'b1;
        send_request(edit_req(tbc_pkg::OP_MOVE_RIGHT, 8'h00, 7'd30));
        send_request(edit_req(tbc_pkg::OP_INSERT, 8'h44, 7'd0));
        send_request(edit_req(tbc_pkg::OP_DELETE, 8'h00, 7'd64));
        send_request(edit_req(tbc_pkg::OP_MOVE_RIGHT, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'h00, 7'd0));
        send_request(edit_req(tbc_pkg::OP_DELETE, 8'h00, 7'd127));
        send_request(edit_req(tbc_pkg::OP_FULL_TEXT, 8'h00, 7'd0));
        send_request(edit_req(tbc_pkg::OP_SHOW_RIGHT, 8'h00, 7'd64));
        wait_for_results();
    endtask

    // The sink parks for a long stretch while requests keep coming, so the
    // request side has to back up.
    task automatic test_receiver_stall();
        sender_idle    = 1'b0;
        sink_idle      = 1'b1;
        long_stall_req = 1'b1;
        repeat (20)
            send_request(random_edit(50));
        wait_for_results();
    endtask

    task automatic test_random_edits();
        int sent;
        int grow;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            sender_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       grow = 20;
                1:       grow = 45;
                default: grow = 75;
            endcase
            repeat (SEGMENT_LEN)
            begin
                send_request(random_edit(grow));
                sent++;
            end
        end
        wait_for_results();
    endtask

    initial
    begin : regression
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edits();
        test_full_buffer();
        test_receiver_stall();
        test_random_edits();
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $error("%0d expected results never arrived", expected_results.size());
        end
        $display("Ran %0d edit requests and checked %0d results, %0d mismatches.",
                 requests_sent, results_checked, mismatch_count);
        $display("Saw %0d refused inserts on a full buffer; longest reply %0d characters.",
                 refused_inserts, longest_reply);
        if (mismatch_count == 0)
            $display("text_buffer_with_cursor regression: pass");
        else
            $display("text_buffer_with_cursor regression: fail");
        $finish;
    end

endmodule
